[rtl/core/hpam_pkg.sv]
package hpam_pkg;

	// table geometry
	localparam int MAX_RULES  = 32;
	localparam int NAME_BYTES = 256;

	localparam int RULE_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CNT_W  = $clog2(MAX_RULES + 1);
	localparam int LEN_W  = $clog2(NAME_BYTES + 1);
	localparam int BYTE_W = $clog2(NAME_BYTES);
	localparam int RA_W   = $clog2(MAX_RULES * NAME_BYTES);
	localparam int DEF_N  = (MAX_RULES < 3) ? MAX_RULES : 3;
	localparam int IDX_W  = 5;

	// item codes
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_RULE  = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic [1:0] KIND_EXACT  = 2'd0;
	localparam logic [1:0] KIND_SUFFIX = 2'd1;
	localparam logic [1:0] KIND_ALL    = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam logic ANS_QUERY = 1'b0;
	localparam logic ANS_RULE  = 1'b1;

	localparam logic [15:0] DEFAULT_PORT = 16'd9443;

	// built-in rule names
	localparam logic [79:0] DEF_A = "demo.local";
	localparam logic [71:0] DEF_B = "127.0.0.1";
	localparam logic [71:0] DEF_C = "localhost";
	localparam int DEF_A_LEN  = (NAME_BYTES < 10) ? NAME_BYTES : 10;
	localparam int DEF_BC_LEN = (NAME_BYTES < 9) ? NAME_BYTES : 9;

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic next_rule;
		logic cmp_start;
		logic cmp_next;
		logic hit;
		logic miss;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic r_done;
		logic port_ok;
		logic len_ok;
		logic kind_all;
		logic rlen_zero;
		logic mismatch;
		logic i_last;
	} dp_stat_t;

	function automatic logic is_ws(logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic [7:0] fold(logic [7:0] c);
		logic [7:0] r;
		r = c;
		if ((c >= 8'h41) && (c <= 8'h5A)) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	function automatic len_t def_len(logic [1:0] s);
		len_t l;
		unique case (s)
			2'd0: l = LEN_W'(DEF_A_LEN);
			2'd1, 2'd2: l = LEN_W'(DEF_BC_LEN);
			default: l = '0;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] def_char(logic [1:0] s, len_t i);
		int k;
		logic [7:0] ch;
		k = int'(i);
		ch = 8'h00;
		unique case (s)
			2'd0: if (k < 10) ch = DEF_A[8*(9-k) +: 8];
			2'd1: if (k < 9) ch = DEF_B[8*(8-k) +: 8];
			2'd2: if (k < 9) ch = DEF_C[8*(8-k) +: 8];
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

[rtl/core/hpam_ram.sv]
module hpam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/hpam_ctrl.sv]
module hpam_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        func,
	input  logic              last,
	input  hpam_pkg::dp_stat_t stat,
	output hpam_pkg::dp_cmd_t  cmd,
	output logic              busy
);
	import hpam_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_META,
		ST_RD,
		ST_CK
	} state_t;

	state_t state_q;
	state_t state_nx;

	// sequence the rule walk
	always_comb begin
		cmd = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
				if (start && (func == FUNC_QUERY) && last) begin
					cmd.scan = 1'b1;
					state_nx = ST_META;
				end
			end
			ST_META: begin
				if (stat.r_done) begin
					cmd.miss = 1'b1;
					state_nx = ST_IDLE;
				end else if (!stat.port_ok || !stat.len_ok) begin
					cmd.next_rule = 1'b1;
				end else if (stat.kind_all || stat.rlen_zero) begin
					cmd.hit = 1'b1;
					state_nx = ST_IDLE;
				end else begin
					cmd.cmp_start = 1'b1;
					state_nx = ST_RD;
				end
			end
			ST_RD: begin
				state_nx = ST_CK;
			end
			ST_CK: begin
				if (stat.mismatch) begin
					cmd.next_rule = 1'b1;
					state_nx = ST_META;
				end else if (stat.i_last) begin
					cmd.hit = 1'b1;
					state_nx = ST_IDLE;
				end else begin
					cmd.cmp_next = 1'b1;
					state_nx = ST_RD;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[rtl/core/hpam_dp.sv]
module hpam_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  hpam_pkg::dp_cmd_t  cmd,
	output hpam_pkg::dp_stat_t stat,
	input  logic [1:0]         func,
	input  logic [7:0]         data_byte,
	input  logic               last,
	input  logic [15:0]        port_value,
	input  logic [1:0]         rule_mode,
	output logic               done,
	output logic               answer_kind,
	output logic               allowed,
	output logic [4:0]         rule_index,
	output logic [1:0]         status
);
	import hpam_pkg::*;

	// rule table metadata
	len_t        rlen_q [MAX_RULES];
	logic [1:0]  kind_q [MAX_RULES];
	logic [15:0] port_q [MAX_RULES];
	logic [DEF_N-1:0] dflt_q;
	cnt_t        count_q;

	// byte collection
	len_t wl_q, wtrim_q, qlen_q, qtrim_q;

	// scan state
	len_t        slen_q, off_q, i_q;
	logic [15:0] qport_q;
	cnt_t        r_q;

	// result register
	logic             done_q;
	logic             kind_out_q, allowed_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0]       status_q;

	logic [7:0] rram_rdata, qram_rdata;

	// incoming byte
	logic [7:0] fb;
	logic       cur_ws, room, w_store, q_store;
	len_t       wl_nx, wtrim_nx, qlen_nx, qtrim_nx;
	logic       rule_acc, query_acc, clear_acc, rule_ok;
	logic [1:0] rule_status;

	assign fb = fold(data_byte);
	assign cur_ws = is_ws(data_byte);
	assign room = (count_q < CNT_W'(MAX_RULES));
	assign w_store = !((wl_q == '0) && cur_ws) && (wl_q < LEN_W'(NAME_BYTES));
	assign q_store = !((qlen_q == '0) && cur_ws) && (qlen_q < LEN_W'(NAME_BYTES));
	assign wl_nx = w_store ? wl_q + LEN_W'(1) : wl_q;
	assign wtrim_nx = (w_store && !cur_ws) ? wl_q + LEN_W'(1) : wtrim_q;
	assign qlen_nx = q_store ? qlen_q + LEN_W'(1) : qlen_q;
	assign qtrim_nx = (q_store && !cur_ws) ? qlen_q + LEN_W'(1) : qtrim_q;
	assign rule_acc = cmd.accept && (func == FUNC_RULE);
	assign query_acc = cmd.accept && (func == FUNC_QUERY);
	assign clear_acc = cmd.accept && (func == FUNC_CLEAR);
	assign rule_ok = (wl_nx != '0) && room;
	assign rule_status = (wl_nx == '0) ? STAT_EMPTY : (room ? STAT_OK : STAT_FULL);

	// selected rule fields
	logic             sel_dflt;
	len_t             rlen;
	logic [1:0]       rkind;
	logic [15:0]      rport;
	logic [7:0]       rbyte;
	logic [RULE_W-1:0] ridx;

	assign ridx = RULE_W'(r_q);
	assign sel_dflt = (r_q < CNT_W'(DEF_N)) && dflt_q[2'(r_q)];
	assign rlen = sel_dflt ? def_len(2'(r_q)) : rlen_q[ridx];
	assign rkind = sel_dflt ? KIND_EXACT : kind_q[ridx];
	assign rport = sel_dflt ? DEFAULT_PORT : port_q[ridx];
	assign rbyte = sel_dflt ? def_char(2'(r_q), i_q) : rram_rdata;

	always_comb begin
		stat = '0;
		stat.r_done = (r_q >= count_q);
		stat.port_ok = (rport == 16'd0) || (rport == qport_q);
		stat.kind_all = (rkind == KIND_ALL);
		stat.rlen_zero = (rlen == '0);
		case (rkind)
			KIND_SUFFIX: stat.len_ok = (slen_q > rlen);
			KIND_ALL: stat.len_ok = 1'b1;
			default: stat.len_ok = (slen_q == rlen);
		endcase
		stat.mismatch = (rbyte != qram_rdata);
		stat.i_last = ((i_q + LEN_W'(1)) == rlen);
	end

	// name stores
	logic [RA_W-1:0]   rram_waddr, rram_raddr;
	logic [BYTE_W-1:0] qram_waddr, qram_raddr;

	assign rram_waddr = RA_W'(count_q) * RA_W'(NAME_BYTES) + RA_W'(wl_q);
	assign rram_raddr = RA_W'(r_q) * RA_W'(NAME_BYTES) + RA_W'(i_q);
	assign qram_waddr = BYTE_W'(qlen_q);
	assign qram_raddr = BYTE_W'(off_q + i_q);

	hpam_ram #(.WIDTH(8), .DEPTH(MAX_RULES * NAME_BYTES)) u_rule_ram (
		.clk  (clk),
		.we   (rule_acc && w_store && room),
		.waddr(rram_waddr),
		.wdata(fb),
		.raddr(rram_raddr),
		.rdata(rram_rdata)
	);

	hpam_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_query_ram (
		.clk  (clk),
		.we   (query_acc && q_store),
		.waddr(qram_waddr),
		.wdata(fb),
		.raddr(qram_raddr),
		.rdata(qram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(DEF_N);
			dflt_q  <= '1;
			wl_q    <= '0;
			wtrim_q <= '0;
			qlen_q  <= '0;
			qtrim_q <= '0;
			r_q     <= '0;
			i_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (clear_acc) begin
				count_q <= '0;
				wl_q    <= '0;
				wtrim_q <= '0;
			end
			if (rule_acc) begin
				if (last) begin
					wl_q    <= '0;
					wtrim_q <= '0;
					done_q  <= 1'b1;
					if (rule_ok) begin
						count_q <= count_q + CNT_W'(1);
						if (count_q < CNT_W'(DEF_N)) begin
							dflt_q[2'(count_q)] <= 1'b0;
						end
					end
				end else begin
					wl_q    <= wl_nx;
					wtrim_q <= wtrim_nx;
				end
			end
			if (query_acc) begin
				if (last) begin
					qlen_q  <= '0;
					qtrim_q <= '0;
					r_q     <= '0;
					// reload built-in rules into an empty table
					if (count_q == '0) begin
						count_q <= CNT_W'(DEF_N);
						dflt_q  <= '1;
						wl_q    <= '0;
						wtrim_q <= '0;
					end
				end else begin
					qlen_q  <= qlen_nx;
					qtrim_q <= qtrim_nx;
				end
			end
			if (cmd.next_rule) begin
				r_q <= r_q + CNT_W'(1);
			end
			if (cmd.cmp_start) begin
				i_q <= '0;
			end
			if (cmd.cmp_next) begin
				i_q <= i_q + LEN_W'(1);
			end
			if (cmd.hit || cmd.miss) begin
				done_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rule_acc && last) begin
			kind_out_q <= ANS_RULE;
			allowed_q  <= 1'b0;
			status_q   <= rule_status;
			idx_q      <= rule_ok ? IDX_W'(count_q) : '0;
			if (rule_ok) begin
				rlen_q[RULE_W'(count_q)] <= wtrim_nx;
				kind_q[RULE_W'(count_q)] <= (rule_mode == KIND_UNUSED) ? KIND_EXACT : rule_mode;
				port_q[RULE_W'(count_q)] <= port_value;
			end
		end
		if (query_acc && last) begin
			slen_q  <= qtrim_nx;
			qport_q <= port_value;
		end
		if (cmd.cmp_start) begin
			off_q <= (rkind == KIND_SUFFIX) ? slen_q - rlen : '0;
		end
		if (cmd.hit || cmd.miss) begin
			kind_out_q <= ANS_QUERY;
			allowed_q  <= cmd.hit;
			status_q   <= STAT_OK;
			idx_q      <= cmd.hit ? IDX_W'(r_q) : '0;
		end
	end

	assign done        = done_q;
	assign answer_kind = kind_out_q;
	assign allowed     = allowed_q;
	assign rule_index  = idx_q;
	assign status      = status_q;

endmodule

[rtl/core/hostname_port_allowlist_matcher_top.sv]
// Host and port allowlist matcher. A request is taken when start is high and
// busy is low; every byte of a rule name, a query byte that is not the last
// one and a clear are taken without raising busy. The last byte of a rule
// answers in the next cycle. The last byte of a query starts a walk of the
// rule table: a check of each rule for its kind, length and port, plus a
// name store read and then a compare for each compared name byte. A miss
// takes one more check, the one that finds the table end; busy is high while
// the walk runs. The answer shows for exactly one cycle with done high and
// must be taken then; it cannot be held off. After reset the table holds
// demo.local, 127.0.0.1 and localhost on port 9443, and no clearing pass is
// needed.
module hostname_port_allowlist_matcher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic [15:0] port_value,
	input  logic [1:0]  rule_mode,
	output logic        done,
	output logic        answer_kind,
	output logic        allowed,
	output logic [4:0]  rule_index,
	output logic [1:0]  status
);
	import hpam_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	hpam_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.last  (last),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	hpam_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.func       (func),
		.data_byte  (data_byte),
		.last       (last),
		.port_value (port_value),
		.rule_mode  (rule_mode),
		.done       (done),
		.answer_kind(answer_kind),
		.allowed    (allowed),
		.rule_index (rule_index),
		.status     (status)
	);

endmodule

[rtl/core/hpam_chk.sv]
module hpam_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  func,
	input logic        last,
	input logic        done,
	input logic        answer_kind,
	input logic        allowed,
	input logic [4:0]  rule_index,
	input logic [1:0]  status
);
	import hpam_pkg::*;

	// a finished query request walks the table
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_QUERY) && last) |=> busy)
		else $error("query end did not start table walk");

	// rule answers never grant
	a_rule_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (answer_kind == ANS_RULE)) |-> !allowed)
		else $error("rule answer carries allowed");

	// query answers carry ok status
	a_query_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (answer_kind == ANS_QUERY)) |-> (status == STAT_OK))
		else $error("query answer with nonzero status");

	// refused or denied answers have index zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (((answer_kind == ANS_QUERY) && !allowed) || (status != STAT_OK)))
		|-> (rule_index == 5'd0))
		else $error("nonzero index without match or commit");

	// a rule answer follows a rule request
	a_rule_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (answer_kind == ANS_RULE))
		|-> $past(start && !busy && (func == FUNC_RULE) && last))
		else $error("rule answer without rule end");

endmodule

bind hostname_port_allowlist_matcher_top hpam_chk u_hpam_chk (.*);

[dv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hpam_pkg::*;

	typedef struct {
		logic [1:0]  func;
		logic [7:0]  data;
		logic        last;
		logic [15:0] port;
		logic [1:0]  mode;
	} req_t;

	typedef struct {
		logic       kind;
		logic       ok;
		logic [4:0] idx;
		logic [1:0] stat;
	} ans_t;

	localparam logic [1:0] FUNC_NOP = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  func = FUNC_CLEAR;
	logic [7:0]  data_byte = 8'h00;
	logic        last = 1'b0;
	logic [15:0] port_value = 16'h0000;
	logic [1:0]  rule_mode = KIND_EXACT;
	logic        busy, done, answer_kind, allowed;
	logic [4:0]  rule_index;
	logic [1:0]  status;

	hostname_port_allowlist_matcher_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .data_byte(data_byte), .last(last), .port_value(port_value),
		.rule_mode(rule_mode), .done(done), .answer_kind(answer_kind),
		.allowed(allowed), .rule_index(rule_index), .status(status)
	);

	// predictor state: rule table and name buffers
	logic [7:0]  rule_store [MAX_RULES][NAME_BYTES];
	int          rule_len [MAX_RULES];
	logic [1:0]  rule_kind [MAX_RULES];
	logic [15:0] rule_pnum [MAX_RULES];
	int          rule_total;
	logic [7:0]  host_buf [NAME_BYTES];
	int          qry_len;
	int          wr_len;

	req_t pending_requests [$];
	ans_t expected_answers [$];
	req_t cur_req;
	logic req_taken = 1'b0;
	int   gap_left = 0;
	bit   burst = 1'b0;
	int   errors = 0;
	int   n_items = 0;
	int   n_queries = 0, n_allowed = 0, n_rules_ok = 0, n_full = 0, n_empty = 0;
	string recent_hosts [$];
	logic [15:0] recent_ports [$];

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit blank(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic void add_builtin(string s);
		for (int i = 0; i < s.len() && i < NAME_BYTES; i++)
			rule_store[rule_total][i] = s[i];
		rule_len[rule_total] = s.len();
		rule_kind[rule_total] = KIND_EXACT;
		rule_pnum[rule_total] = DEFAULT_PORT;
		rule_total++;
	endfunction

	function automatic void load_builtin();
		rule_total = 0;
		add_builtin("demo.local");
		add_builtin("127.0.0.1");
		add_builtin("localhost");
	endfunction

	function automatic bit name_hit(int r);
		int off;
		if (rule_kind[r] == KIND_ALL)
			return 1'b1;
		if (rule_kind[r] == KIND_SUFFIX) begin
			if (qry_len <= rule_len[r])
				return 1'b0;
			off = qry_len - rule_len[r];
		end else begin
			if (qry_len != rule_len[r])
				return 1'b0;
			off = 0;
		end
		for (int i = 0; i < rule_len[r]; i++)
			if (host_buf[off + i] != rule_store[r][i])
				return 1'b0;
		return 1'b1;
	endfunction

	// advance the predictor by one accepted request
	function automatic void predict_answer(req_t r, output bit has_ans, output ans_t a);
		bit room;
		has_ans = 1'b0;
		a = '{kind: ANS_QUERY, ok: 1'b0, idx: 5'd0, stat: STAT_OK};
		case (r.func)
			FUNC_CLEAR: begin
				rule_total = 0;
				wr_len = 0;
			end
			FUNC_RULE: begin
				room = rule_total < MAX_RULES;
				if (!(wr_len == 0 && blank(r.data)) && wr_len < NAME_BYTES) begin
					if (room)
						rule_store[rule_total][wr_len] = lower(r.data);
					wr_len++;
				end
				if (r.last) begin
					has_ans = 1'b1;
					a.kind = ANS_RULE;
					if (wr_len == 0) begin
						a.stat = STAT_EMPTY;
					end else if (!room) begin
						a.stat = STAT_FULL;
					end else begin
						while (wr_len > 0 && blank(rule_store[rule_total][wr_len-1]))
							wr_len--;
						rule_len[rule_total] = wr_len;
						rule_kind[rule_total] = (r.mode == KIND_UNUSED) ? KIND_EXACT : r.mode;
						rule_pnum[rule_total] = r.port;
						a.idx = 5'(rule_total);
						rule_total++;
					end
					wr_len = 0;
				end
			end
			FUNC_QUERY: begin
				if (!(qry_len == 0 && blank(r.data)) && qry_len < NAME_BYTES) begin
					host_buf[qry_len] = lower(r.data);
					qry_len++;
				end
				if (r.last) begin
					while (qry_len > 0 && blank(host_buf[qry_len-1]))
						qry_len--;
					if (rule_total == 0) begin
						load_builtin();
						wr_len = 0;
					end
					has_ans = 1'b1;
					for (int k = 0; k < rule_total; k++) begin
						if (rule_pnum[k] != 0 && rule_pnum[k] != r.port)
							continue;
						if (name_hit(k)) begin
							a.ok = 1'b1;
							a.idx = 5'(k);
							break;
						end
					end
					qry_len = 0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void push_req(logic [1:0] f, logic [7:0] d, logic l,
			logic [15:0] p, logic [1:0] m);
		pending_requests.push_back('{func: f, data: d, last: l, port: p, mode: m});
		n_items++;
	endfunction

	function automatic void push_name(logic [1:0] f, string s, logic [15:0] p, logic [1:0] m);
		for (int i = 0; i < s.len(); i++)
			push_req(f, s[i], i == s.len() - 1, p, m);
	endfunction

	function automatic string rand_host();
		string labels [8] = '{"web", "corp", "net", "a", "x1", "api", "svc", "io"};
		string s;
		int n;
		n = $urandom_range(1, 3);
		s = labels[$urandom_range(0, 7)];
		for (int i = 1; i < n; i++)
			s = {labels[$urandom_range(0, 7)], ".", s};
		return s;
	endfunction

	// flip letter case and pad with whitespace at random
	function automatic string dress(string s);
		string ws = " \t\n\v\f\r";
		string o;
		o = s;
		for (int i = 0; i < o.len(); i++)
			if (o[i] >= "a" && o[i] <= "z" && $urandom_range(0, 3) == 0)
				o[i] = o[i] - 8'd32;
		if ($urandom_range(0, 3) == 0)
			o = {ws.substr($urandom_range(0, 5), 5), o};
		if ($urandom_range(0, 3) == 0)
			o = {o, ws.substr($urandom_range(0, 5), 5)};
		return o;
	endfunction

	function automatic string noise(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, " "};
		for (int i = 0; i < n; i++)
			s[i] = 8'($urandom_range(1, 255));
		return s;
	endfunction

	function automatic logic [15:0] rand_port();
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return DEFAULT_PORT;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] query_port();
		if (recent_ports.size() != 0 && $urandom_range(0, 3) != 0)
			return recent_ports[$urandom_range(0, recent_ports.size() - 1)];
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic void rand_rule();
		string h;
		logic [1:0] m;
		logic [15:0] p;
		h = rand_host();
		m = 2'($urandom_range(0, 3));
		p = rand_port();
		recent_hosts.push_back(h);
		recent_ports.push_back(p);
		if (recent_hosts.size() > 16) begin
			void'(recent_hosts.pop_front());
			void'(recent_ports.pop_front());
		end
		push_name(FUNC_RULE, dress(m == KIND_SUFFIX ? {".", h} : h), p, m);
	endfunction

	function automatic void rand_query();
		string h;
		if (recent_hosts.size() != 0 && $urandom_range(0, 3) != 0) begin
			h = recent_hosts[$urandom_range(0, recent_hosts.size() - 1)];
			if ($urandom_range(0, 1))
				h = {rand_host(), ".", h};
		end else begin
			h = rand_host();
		end
		push_name(FUNC_QUERY, dress(h), query_port(), 2'($urandom_range(0, 3)));
	endfunction

	function automatic void directed_part();
		string longname;
		longname = {noise(0), ""};
		for (int i = 0; i < 300; i++)
			longname = {longname, "q"};
		push_name(FUNC_QUERY, "localhost", DEFAULT_PORT, KIND_EXACT);
		push_name(FUNC_QUERY, " LocalHost\t", 16'd80, KIND_EXACT);
		push_name(FUNC_RULE, " \t ", 16'hFFFF, KIND_EXACT);
		push_name(FUNC_RULE, ".Corp.Net ", 16'd0, KIND_SUFFIX);
		push_name(FUNC_QUERY, "a.corp.net", 16'd7, KIND_ALL);
		push_name(FUNC_QUERY, "corp.net", 16'd7, KIND_EXACT);
		push_req(FUNC_RULE, 8'hFF, 1'b0, 16'hFFFF, KIND_UNUSED);
		push_req(FUNC_RULE, 8'h00, 1'b1, 16'hFFFF, KIND_UNUSED);
		push_name(FUNC_RULE, "*", 16'd1234, KIND_ALL);
		push_name(FUNC_QUERY, "   ", 16'd1234, KIND_EXACT);
		push_req(FUNC_NOP, 8'hAA, 1'b1, 16'h5555, KIND_UNUSED);
		push_name(FUNC_RULE, "ab", 16'd1, KIND_EXACT);
		push_req(FUNC_CLEAR, 8'h00, 1'b0, 16'd0, KIND_EXACT);
		push_name(FUNC_QUERY, "DEMO.local", DEFAULT_PORT, KIND_EXACT);
		// names past the buffer size get truncated
		push_name(FUNC_RULE, longname, 16'd0, KIND_EXACT);
		push_name(FUNC_QUERY, longname, 16'd5, KIND_EXACT);
		// fill the table, then one more rule is refused
		push_req(FUNC_CLEAR, 8'h00, 1'b1, 16'd0, KIND_EXACT);
		for (int i = 0; i <= MAX_RULES; i++)
			push_name(FUNC_RULE, $sformatf("h%0d", i), 16'(i), KIND_EXACT);
		push_name(FUNC_QUERY, "h31", 16'd31, KIND_EXACT);
	endfunction

	// driver: hold a request until taken, then idle a drawn number of cycles
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !req_taken) begin
			end else if (gap_left != 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_requests.size() != 0) begin
				cur_req = pending_requests.pop_front();
				func <= cur_req.func;
				data_byte <= cur_req.data;
				last <= cur_req.last;
				port_value <= cur_req.port;
				rule_mode <= cur_req.mode;
				start <= 1'b1;
				if ($urandom_range(0, 99) == 0)
					burst = ~burst;
				gap_left <= burst ? 0 : $urandom_range(0, 7);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check answers, then predict for the request taken at this edge
	always @(posedge clk) begin
		bit has_ans;
		ans_t a, e;
		if (arst_n) begin
			if (done) begin
				if (expected_answers.size() == 0) begin
					$error("answer with nothing expected");
					errors++;
				end else begin
					e = expected_answers.pop_front();
					if (answer_kind !== e.kind) begin
						$error("answer_kind exp %0d got %0d", e.kind, answer_kind);
						errors++;
					end
					if (allowed !== e.ok) begin
						$error("allowed exp %0d got %0d", e.ok, allowed);
						errors++;
					end
					if (rule_index !== e.idx) begin
						$error("rule_index exp %0d got %0d", e.idx, rule_index);
						errors++;
					end
					if (status !== e.stat) begin
						$error("status exp %0d got %0d", e.stat, status);
						errors++;
					end
				end
			end
			req_taken <= start && !busy;
			if (start && !busy) begin
				predict_answer(cur_req, has_ans, a);
				if (has_ans) begin
					expected_answers.push_back(a);
					if (a.kind == ANS_QUERY) begin
						n_queries++;
						n_allowed += a.ok;
					end else begin
						n_rules_ok += (a.stat == STAT_OK);
						n_full += (a.stat == STAT_FULL);
						n_empty += (a.stat == STAT_EMPTY);
					end
				end
			end
		end
	end

	initial begin
		#500ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int pick;
		load_builtin();
		qry_len = 0;
		wr_len = 0;
		directed_part();
		while (n_items < 1300) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				rand_query();
			else if (pick < 65)
				rand_rule();
			else if (pick < 70)
				push_req(FUNC_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom), 2'($urandom));
			else if (pick < 80)
				push_name(pick < 75 ? FUNC_QUERY : FUNC_RULE, noise($urandom_range(1, 12)),
					16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)));
			else if (pick < 83)
				push_req(FUNC_NOP, 8'($urandom), 1'($urandom), 16'($urandom), 2'($urandom));
			else if (pick < 85)
				for (int i = 0; i < MAX_RULES + 2; i++)
					rand_rule();
			else
				push_name(FUNC_QUERY, dress(rand_host()), query_port(), KIND_EXACT);
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		do @(posedge clk); while (pending_requests.size() != 0 || start);
		do @(posedge clk); while (expected_answers.size() != 0);
		repeat (10) @(posedge clk);
		$display("Covered %0d requests: %0d queries (%0d allowed), %0d rules stored,",
			n_items, n_queries, n_allowed, n_rules_ok);
		$display("%0d rules refused on a full table, %0d empty rule names.", n_full, n_empty);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

[files.f]
rtl/core/hpam_pkg.sv
rtl/core/hpam_ram.sv
rtl/core/hpam_ctrl.sv
rtl/core/hpam_dp.sv
rtl/core/hostname_port_allowlist_matcher_top.sv
rtl/core/hpam_chk.sv
dv/tb_top.sv
